[src/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, types and helper functions for the differential drive
// odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // CORDIC iteration count and loop counter width
    localparam int CORDIC_STEPS = 24;
    localparam int IT_W         = $clog2(CORDIC_STEPS);

    // Fixed-point constants
    localparam logic [31:0] INV_TWO_PI  = 32'd683565276;  // 2^32/(2*pi), Q0.32
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;  // 1/K in Q1.30
    localparam logic [31:0] US_PER_S    = 32'd1000000;

    // Magnitude width of a velocity numerator (delta * 1e6)
    localparam int DIV_W = 61;
    localparam int DCNT_W = $clog2(DIV_W);

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DIST_PER_COUNT = 2'd0;
    localparam t_cfg_idx CFG_ROT_GAIN       = 2'd1;

    // Reset values of the configuration registers
    localparam logic [31:0] DPC_RESET  = 32'd2248840;
    localparam logic [23:0] GAIN_RESET = 24'd218453;

    // Saturation limits
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    // Arctangent table, binary angle in Q1.30 (2^30 = quarter turn)
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[src/ddo_if.sv]
// ----------------------------------------------------------------------------
// ddo interfaces
// Valid/ready channels for encoder items, odometry results and register writes.
// ----------------------------------------------------------------------------
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        elapsed_us;

    modport source (output valid, left_count, right_count, elapsed_us, input ready);
    modport sink   (input valid, left_count, right_count, elapsed_us, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic               time_invalid;

    modport source (output valid, pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,
                    time_invalid, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,
                    time_invalid, output ready);
endinterface

interface ddo_cfg_if;
    logic              valid;
    logic              ready;
    ddo_pkg::t_cfg_idx index;
    logic [31:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/ddo_divider.sv]
// ----------------------------------------------------------------------------
// ddo_divider
// Restoring unsigned divider, one quotient bit per cycle. Divisor must stay
// stable while busy; quotient holds after done until the next start.
// ----------------------------------------------------------------------------
module ddo_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ddo_pkg::DIV_W-1:0] i_num,
    input  logic [31:0]               i_den,
    output logic                      o_done,
    output logic [ddo_pkg::DIV_W-1:0] o_quo
);
    import ddo_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]       r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [32:0]       rem_sh;
    logic              fits;

    // trial subtract of the shifted remainder
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign fits   = (rem_sh >= {1'b0, i_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(DIV_W - 1);
            n_rem  = '0;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = fits ? 32'(rem_sh - {1'b0, i_den}) : rem_sh[31:0];
            n_quo = {r_quo[DIV_W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    // checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> r_done)
        else $error("divider missed done");

endmodule

[src/differential_drive_odometry_core.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Sequence: wheel distances, heading and a CORDIC loop to position, then
//   three divided velocities (x, y, yaw); the velocity divisions are
//   skipped when elapsed time is zero.
// Throughput: one item at a time; set by the bit-serial divider (once per
//   velocity) and the CORDIC loop. A new item is taken once the result is taken.
// Reset: synchronous active low; clears position, heading, previous counts and
//   restores the register defaults.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ddo_in_if.sink   i_item,
    ddo_cfg_if.sink  i_cfg,
    ddo_out_if.source o_res
);
    import ddo_pkg::*;

    // sequencer states
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_M_WL    = 5'd1;
    localparam logic [4:0] ST_M_WR    = 5'd2;
    localparam logic [4:0] ST_WR      = 5'd3;
    localparam logic [4:0] ST_M_TURN  = 5'd4;
    localparam logic [4:0] ST_TURN    = 5'd5;
    localparam logic [4:0] ST_M_HHI   = 5'd6;
    localparam logic [4:0] ST_M_HLO   = 5'd7;
    localparam logic [4:0] ST_M_THI   = 5'd8;
    localparam logic [4:0] ST_M_TLO   = 5'd9;
    localparam logic [4:0] ST_TLO     = 5'd10;
    localparam logic [4:0] ST_CORDIC  = 5'd11;
    localparam logic [4:0] ST_ROT     = 5'd12;
    localparam logic [4:0] ST_M_DX    = 5'd13;
    localparam logic [4:0] ST_M_DY    = 5'd14;
    localparam logic [4:0] ST_DY      = 5'd15;
    localparam logic [4:0] ST_POS     = 5'd16;
    localparam logic [4:0] ST_M_VEL   = 5'd17;
    localparam logic [4:0] ST_M_VEL2  = 5'd18;
    localparam logic [4:0] ST_VEL3    = 5'd19;
    localparam logic [4:0] ST_DIV_GO  = 5'd20;
    localparam logic [4:0] ST_DIV     = 5'd21;
    localparam logic [4:0] ST_DIV_END = 5'd22;
    localparam logic [4:0] ST_OUT     = 5'd23;

    // velocity selector codes
    localparam logic [1:0] VS_X   = 2'd0;
    localparam logic [1:0] VS_Y   = 2'd1;
    localparam logic [1:0] VS_YAW = 2'd2;

    logic [4:0]  r_state, n_state;

    // configuration
    logic [31:0] r_dpc;
    logic [23:0] r_gain;

    // odometry state
    logic [31:0]        r_prev_l, r_prev_r;
    logic signed [31:0] r_acc_x, r_acc_y;
    logic [31:0]        r_acc_h;

    // per-item working registers
    logic [31:0]        r_lc, r_rc, r_us;
    logic signed [31:0] r_dl, r_dr;
    logic signed [31:0] r_wl, r_wr;
    logic signed [32:0] r_wdiff;
    logic signed [31:0] r_travel;
    logic signed [56:0] r_turn;
    logic [31:0]        r_hang, r_dang;
    logic signed [32:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic [1:0]         r_quad;
    logic [IT_W-1:0]    r_it;
    logic signed [32:0] r_c, r_s;
    logic signed [32:0] r_dx, r_dy;
    logic [1:0]         r_vsel;
    logic signed [61:0] r_num;
    logic               r_neg;
    logic signed [31:0] r_vx, r_vy, r_vw;
    logic               r_inval;

    // shared multiplier
    logic signed [32:0] m_a, m_b;
    logic signed [65:0] r_prod;

    // divider link
    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_num, div_quo;

    // misc combinational
    logic signed [31:0] wr_sat;
    logic [31:0]        ang;
    logic signed [32:0] cx_sh, cy_sh;
    logic signed [31:0] atan_v;
    logic signed [33:0] sum_x, sum_y;
    logic signed [61:0] num_abs;
    logic signed [31:0] vel_sat;

    // ---- configuration port ----
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpc  <= DPC_RESET;
            r_gain <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DIST_PER_COUNT: r_dpc  <= i_cfg.data;
                CFG_ROT_GAIN:       r_gain <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

    // ---- multiplier operand select ----
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_M_WL:   begin m_a = 33'(r_dl);   m_b = {1'b0, r_dpc}; end
            ST_M_WR:   begin m_a = 33'(r_dr);   m_b = {1'b0, r_dpc}; end
            ST_M_TURN: begin m_a = r_wdiff;     m_b = {9'b0, r_gain}; end
            ST_M_HHI:  begin
                m_a = 33'($signed(r_turn[56:33])); m_b = {1'b0, INV_TWO_PI};
            end
            ST_M_HLO:  begin m_a = {1'b0, r_turn[32:1]}; m_b = {1'b0, INV_TWO_PI}; end
            ST_M_THI:  begin
                m_a = 33'($signed(r_turn[56:32])); m_b = {1'b0, INV_TWO_PI};
            end
            ST_M_TLO:  begin m_a = {1'b0, r_turn[31:0]}; m_b = {1'b0, INV_TWO_PI}; end
            ST_M_DX:   begin m_a = 33'(r_travel); m_b = r_c; end
            ST_M_DY:   begin m_a = 33'(r_travel); m_b = r_s; end
            ST_M_VEL: begin
                m_b = {1'b0, US_PER_S};
                case (r_vsel)
                    VS_X:    m_a = r_dx;
                    VS_Y:    m_a = r_dy;
                    default: m_a = 33'($signed(r_turn[56:40]));
                endcase
            end
            ST_M_VEL2: begin m_a = {9'b0, r_turn[39:16]}; m_b = {1'b0, US_PER_S}; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // ---- helpers ----
    assign wr_sat = sat32(r_prod >>> 16);
    assign ang    = r_acc_h + r_hang;
    assign cx_sh  = r_cy >>> r_it;
    assign cy_sh  = r_cx >>> r_it;
    assign atan_v = $signed(atan_lut(5'(r_it)));
    assign sum_x  = 34'(r_acc_x) + 34'(r_dx);
    assign sum_y  = 34'(r_acc_y) + 34'(r_dy);
    assign num_abs = r_num[61] ? -r_num : r_num;
    assign div_num = num_abs[DIV_W-1:0];
    assign div_start = (r_state == ST_DIV_GO);

    // signed, saturated quotient
    always_comb begin
        if (!r_neg) begin
            vel_sat = (div_quo[DIV_W-1:31] == '0) ? $signed(div_quo[31:0])
                                                   : 32'sh7FFFFFFF;
        end else if (div_quo[DIV_W-1:32] == '0 &&
                     (!div_quo[31] || div_quo[30:0] == '0)) begin
            vel_sat = -$signed(div_quo[31:0]);
        end else begin
            vel_sat = 32'sh80000000;
        end
    end

    ddo_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_us),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_item.valid) n_state = ST_M_WL;
            ST_M_WL:    n_state = ST_M_WR;
            ST_M_WR:    n_state = ST_WR;
            ST_WR:      n_state = ST_M_TURN;
            ST_M_TURN:  n_state = ST_TURN;
            ST_TURN:    n_state = ST_M_HHI;
            ST_M_HHI:   n_state = ST_M_HLO;
            ST_M_HLO:   n_state = ST_M_THI;
            ST_M_THI:   n_state = ST_M_TLO;
            ST_M_TLO:   n_state = ST_TLO;
            ST_TLO:     n_state = ST_CORDIC;
            ST_CORDIC:  if (r_it == IT_W'(CORDIC_STEPS - 1)) n_state = ST_ROT;
            ST_ROT:     n_state = ST_M_DX;
            ST_M_DX:    n_state = ST_M_DY;
            ST_M_DY:    n_state = ST_DY;
            ST_DY:      n_state = ST_POS;
            ST_POS:     n_state = (r_us == '0) ? ST_OUT : ST_M_VEL;
            ST_M_VEL:   n_state = ST_M_VEL2;
            ST_M_VEL2:  n_state = (r_vsel == VS_YAW) ? ST_VEL3 : ST_DIV_GO;
            ST_VEL3:    n_state = ST_DIV_GO;
            ST_DIV_GO:  n_state = ST_DIV;
            ST_DIV:     if (div_done) n_state = ST_DIV_END;
            ST_DIV_END: n_state = (r_vsel == VS_YAW) ? ST_OUT : ST_M_VEL;
            ST_OUT:     if (o_res.ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // ---- control and odometry state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_acc_h  <= '0;
            r_it     <= '0;
            r_vsel   <= VS_X;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_TLO:    r_it <= '0;
                ST_CORDIC: r_it <= r_it + 1'b1;
                ST_POS: begin
                    r_acc_x  <= sat32(66'(sum_x));
                    r_acc_y  <= sat32(66'(sum_y));
                    r_acc_h  <= r_acc_h + r_dang;
                    r_prev_l <= r_lc;
                    r_prev_r <= r_rc;
                    r_vsel   <= VS_X;
                end
                ST_DIV_END: r_vsel <= r_vsel + 1'b1;
                default: ;
            endcase
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_lc <= i_item.left_count;
                r_rc <= i_item.right_count;
                r_us <= i_item.elapsed_us;
                r_dl <= $signed(i_item.left_count - r_prev_l);
                r_dr <= $signed(i_item.right_count - r_prev_r);
            end
            ST_M_WR: r_wl <= sat32(r_prod >>> 16);
            ST_WR: begin
                r_wr    <= wr_sat;
                r_wdiff <= 33'(r_wl) - 33'(wr_sat);
            end
            ST_M_TURN: r_travel <= 32'((33'(r_wl) + 33'(r_wr)) >>> 1);
            ST_TURN:   r_turn   <= r_prod[56:0];
            ST_M_HLO:  r_hang   <= r_prod[31:0];
            ST_M_THI:  r_hang   <= r_hang + r_prod[63:32];
            ST_M_TLO:  r_dang   <= r_prod[31:0];
            ST_TLO: begin
                r_dang <= r_dang + r_prod[63:32];
                r_cx   <= {1'b0, CORDIC_GAIN};
                r_cy   <= '0;
                r_cz   <= {2'b00, ang[29:0]};
                r_quad <= ang[31:30];
            end
            // one micro-rotation per cycle
            ST_CORDIC: begin
                if (r_cz >= 0) begin
                    r_cx <= r_cx - cx_sh;
                    r_cy <= r_cy + cy_sh;
                    r_cz <= r_cz - atan_v;
                end else begin
                    r_cx <= r_cx + cx_sh;
                    r_cy <= r_cy - cy_sh;
                    r_cz <= r_cz + atan_v;
                end
            end
            // fold the result into its quadrant
            ST_ROT: begin
                case (r_quad)
                    2'd0:    begin r_c <= r_cx;  r_s <= r_cy;  end
                    2'd1:    begin r_c <= -r_cy; r_s <= r_cx;  end
                    2'd2:    begin r_c <= -r_cx; r_s <= -r_cy; end
                    default: begin r_c <= r_cy;  r_s <= -r_cx; end
                endcase
            end
            ST_M_DY: r_dx <= r_prod[62:30];
            ST_DY:   r_dy <= r_prod[62:30];
            ST_POS: begin
                r_inval <= (r_us == '0);
                r_vx    <= '0;
                r_vy    <= '0;
                r_vw    <= '0;
            end
            ST_M_VEL2: r_num <= (r_vsel == VS_YAW) ? {r_prod[37:0], 24'b0} : r_prod[61:0];
            ST_VEL3:   r_num <= r_num + r_prod[61:0];
            ST_DIV_GO: r_neg <= r_num[61];
            ST_DIV_END: begin
                case (r_vsel)
                    VS_X:    r_vx <= vel_sat;
                    VS_Y:    r_vy <= vel_sat;
                    default: r_vw <= vel_sat;
                endcase
            end
            default: ;
        endcase
    end

    // ---- handshakes and result ----
    assign i_item.ready       = (r_state == ST_IDLE);
    assign o_res.valid        = (r_state == ST_OUT);
    assign o_res.pos_x        = r_acc_x;
    assign o_res.pos_y        = r_acc_y;
    assign o_res.heading      = r_acc_h;
    assign o_res.vel_x        = r_vx;
    assign o_res.vel_y        = r_vy;
    assign o_res.yaw_rate     = r_vw;
    assign o_res.time_invalid = r_inval;

    // checks
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_item.ready && o_res.valid)) else $error("input open while result pending");
    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == ST_M_WL))
        else $error("accepted item did not start the sequence");
    a_inval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.time_invalid) |->
        (o_res.vel_x == 0 && o_res.vel_y == 0 && o_res.yaw_rate == 0))
        else $error("nonzero velocity with zero elapsed time");
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV)) else $error("divider done outside wait state");

endmodule
